// File: src/masked_gray_level_quantizer_top_defines.svh
// assertion macros for the masked gray level quantizer
// used by the top level; expects clk and rst in the including scope
`ifndef MASKED_GRAY_LEVEL_QUANTIZER_TOP_DEFINES_SVH
`define MASKED_GRAY_LEVEL_QUANTIZER_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define MGLQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define MGLQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MGLQ_ASSERT(name, prop, msg)
`define MGLQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: src/mglq_pkg.sv
// shared types, codes and constants of the masked gray level quantizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mglq_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int COUNT_BITS = 24;
  localparam int DIV_BITS   = 24;
  localparam int LEVEL_BITS = 9;

  localparam logic [7:0] MASK_INSIDE = 8'd255;

  // actions
  localparam logic [1:0] ACT_CLEAR    = 2'd0;
  localparam logic [1:0] ACT_MEASURE  = 2'd1;
  localparam logic [1:0] ACT_QUANTIZE = 2'd2;

  // methods
  localparam logic [1:0] MTH_FIXED_RANGE = 2'd0;
  localparam logic [1:0] MTH_REGION      = 2'd1;
  localparam logic [1:0] MTH_BIN_WIDTH   = 2'd2;
  localparam logic [1:0] MTH_PASS        = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_EMPTY_REGION  = 3'd1;
  localparam logic [2:0] ERR_TOO_MANY_BINS = 3'd2;
  localparam logic [2:0] ERR_VALUE_LARGE   = 3'd3;
  localparam logic [2:0] ERR_RANGE_REV     = 3'd4;

  // register indexes
  localparam logic [2:0] REG_METHOD      = 3'd0;
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd1;
  localparam logic [2:0] REG_RANGE_LOW   = 3'd2;
  localparam logic [2:0] REG_RANGE_HIGH  = 3'd3;
  localparam logic [2:0] REG_BIN_WIDTH   = 3'd4;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [DIV_BITS-1:0]   div_word_t;

  typedef struct packed {
    logic [1:0] action;
    pixel_t     pixel_value;
    logic [7:0] mask_byte;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [2:0] error_code;
    pixel_t     lower_bound;
    pixel_t     upper_bound;
    count_t     inside_count;
  } result_item_t;

  typedef struct packed {
    logic [1:0]            method;
    logic [LEVEL_BITS-1:0] level_count;
    pixel_t                range_low;
    pixel_t                range_high;
    logic [23:0]           bin_width_fx;
  } cfg_t;

  typedef struct packed {
    logic   clear;
    logic   measure;
    pixel_t value;
  } stats_upd_t;

  typedef struct packed {
    pixel_t region_min;
    pixel_t region_max;
    count_t region_count;
  } stats_t;

  typedef struct packed {
    logic      start;
    div_word_t dividend;
    div_word_t divisor;
  } div_cmd_t;

  typedef struct packed {
    logic      done;
    div_word_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/mglq_cfg.sv
// configuration registers behind an apb-style port
// depends on mglq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mglq_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output mglq_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method       <= mglq_pkg::MTH_REGION;
      cfg.level_count  <= 9'd256;
      cfg.range_low    <= '0;
      cfg.range_high   <= '1;
      cfg.bin_width_fx <= 24'd256;
    end else if (wr_en) begin
      unique case (reg_index)
        mglq_pkg::REG_METHOD:      cfg.method       <= pwdata[1:0];
        mglq_pkg::REG_LEVEL_COUNT: cfg.level_count  <= pwdata[8:0];
        mglq_pkg::REG_RANGE_LOW:   cfg.range_low    <= pwdata[15:0];
        mglq_pkg::REG_RANGE_HIGH:  cfg.range_high   <= pwdata[15:0];
        mglq_pkg::REG_BIN_WIDTH:   cfg.bin_width_fx <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mglq_pkg::REG_METHOD:      prdata = {30'd0, cfg.method};
      mglq_pkg::REG_LEVEL_COUNT: prdata = {23'd0, cfg.level_count};
      mglq_pkg::REG_RANGE_LOW:   prdata = {16'd0, cfg.range_low};
      mglq_pkg::REG_RANGE_HIGH:  prdata = {16'd0, cfg.range_high};
      mglq_pkg::REG_BIN_WIDTH:   prdata = {8'd0, cfg.bin_width_fx};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/mglq_stats.sv
// region statistics: running minimum, maximum and saturating count
// depends on mglq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mglq_stats (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mglq_pkg::stats_upd_t upd,
  output mglq_pkg::stats_t          stats
);

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      stats.region_min   <= '1;
      stats.region_max   <= '0;
      stats.region_count <= '0;
    end else if (upd.measure) begin
      if (upd.value < stats.region_min) begin
        stats.region_min <= upd.value;
      end
      if (upd.value > stats.region_max) begin
        stats.region_max <= upd.value;
      end
      // saturate at all ones
      if (stats.region_count != '1) begin
        stats.region_count <= stats.region_count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/mglq_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on mglq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mglq_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mglq_pkg::div_cmd_t cmd,
  output mglq_pkg::div_rsp_t      rsp
);

  localparam int DW = mglq_pkg::DIV_BITS;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] divisor;
  logic [DW:0]   shifted;
  logic [DW+1:0] trial;

  assign shifted = {rem, quo[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy && (cnt == CW'(1));
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt  <= cnt - 1'b1;
        busy <= (cnt != CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= '0;
      quo     <= cmd.dividend;
      divisor <= cmd.divisor;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// File: src/masked_gray_level_quantizer_top.sv
// masked gray level quantizer: top level with the item sequencer
// depends on mglq_pkg, mglq_cfg, mglq_stats, mglq_div and the defines header
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  pixel    | in        | pixel_valid / pixel_stall    | action, pixel_value, mask_byte
//  result   | out       | result_valid / result_stall  | level, error_code, bounds, count
//  apb      | in        | psel / penable / pready      | paddr, pwdata, prdata
//
//  clear, measure and ignored items: no result, the pixel input stays free for the next item
//  quantize item: setup, then in bin width mode a bin count division (check), then the level
//    division (scale, level div) for a value in the mask and above the lower bound, then done;
//    pass mode, a setup error or too many bins skip the level division
//  rst is synchronous: configuration registers, region statistics and the sequencer reset at once
//  a stalled result holds the sequencer in its final state and keeps pixel_stall high
`timescale 1ns / 1ps
`default_nettype none
`include "masked_gray_level_quantizer_top_defines.svh"

module masked_gray_level_quantizer_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  // pixel items
  input  wire logic                   pixel_valid,
  output logic                        pixel_stall,
  input  wire mglq_pkg::pixel_item_t  pixel,
  // result items
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output mglq_pkg::result_item_t      result
);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SETUP     = 3'd1;
  localparam logic [2:0] S_CHECK     = 3'd2;
  localparam logic [2:0] S_SCALE     = 3'd3;
  localparam logic [2:0] S_LEVEL_DIV = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  localparam int LB = mglq_pkg::LEVEL_BITS;
  localparam int DW = mglq_pkg::DIV_BITS;

  mglq_pkg::cfg_t       cfg;
  mglq_pkg::stats_t     stats;
  mglq_pkg::stats_upd_t stats_upd;
  mglq_pkg::div_cmd_t   div_cmd;
  mglq_pkg::div_rsp_t   div_rsp;

  logic [2:0]          state;
  logic [2:0]          state_next;

  // captured item and per-item working registers
  mglq_pkg::pixel_t    value;
  logic                in_mask;
  mglq_pkg::pixel_t    lower;
  mglq_pkg::pixel_t    upper;
  logic [2:0]          err;
  logic [LB-1:0]       levels;
  logic [7:0]          level;

  logic                accept;
  logic                item_inside;
  logic                out_free;

  // setup evaluation
  logic [LB-1:0]       levels_s;
  mglq_pkg::pixel_t    lower_s;
  mglq_pkg::pixel_t    upper_s;
  logic [2:0]          err_s;
  logic [LB-1:0]       levels_m1;
  logic [7:0]          pass_level;

  // scaling datapath
  mglq_pkg::pixel_t    diff;
  logic [16:0]         span;
  logic [24:0]         product;
  logic [DW-1:0]       quot_sat_ref;
  logic [7:0]          quot_level;

  mglq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mglq_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .upd   (stats_upd),
    .stats (stats)
  );

  mglq_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  // input side: one item at a time, stats change only on accept
  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign item_inside = (pixel.mask_byte == mglq_pkg::MASK_INSIDE);

  assign stats_upd.clear   = accept && (pixel.action == mglq_pkg::ACT_CLEAR);
  assign stats_upd.measure = accept && (pixel.action == mglq_pkg::ACT_MEASURE) && item_inside;
  assign stats_upd.value   = pixel.pixel_value;

  assign out_free = !result_valid || !result_stall;

  // level count clamped to 2..256
  always_comb begin
    if (cfg.level_count < LB'(2)) begin
      levels_s = LB'(2);
    end else if (cfg.level_count > LB'(256)) begin
      levels_s = LB'(256);
    end else begin
      levels_s = cfg.level_count;
    end
  end

  // bounds and setup checks, first match wins
  always_comb begin
    lower_s = '0;
    upper_s = '0;
    err_s   = mglq_pkg::ERR_NONE;
    if ((cfg.method == mglq_pkg::MTH_REGION || cfg.method == mglq_pkg::MTH_BIN_WIDTH)
        && stats.region_count == '0) begin
      err_s = mglq_pkg::ERR_EMPTY_REGION;
    end else if (cfg.method == mglq_pkg::MTH_FIXED_RANGE) begin
      lower_s = cfg.range_low;
      upper_s = cfg.range_high;
      if (cfg.range_high < cfg.range_low) begin
        err_s = mglq_pkg::ERR_RANGE_REV;
      end
    end else if (cfg.method == mglq_pkg::MTH_REGION) begin
      lower_s = stats.region_min;
      upper_s = stats.region_max;
    end else if (cfg.method == mglq_pkg::MTH_BIN_WIDTH) begin
      lower_s = stats.region_min;
      upper_s = stats.region_max;
      if (cfg.bin_width_fx == '0) begin
        err_s = mglq_pkg::ERR_TOO_MANY_BINS;
      end
    end else begin
      upper_s = 16'(levels_s - 1'b1);
      if (stats.region_count != '0 && stats.region_max >= 16'(levels_s)) begin
        err_s = mglq_pkg::ERR_VALUE_LARGE;
      end
    end
  end

  // pass-through level, saturated at levels-1
  always_comb begin
    levels_m1 = levels_s - 1'b1;
    if (value > 16'(levels_m1)) begin
      pass_level = levels_m1[7:0];
    end else begin
      pass_level = value[7:0];
    end
  end

  // scaling operands for the level division
  assign diff    = value - lower;
  assign span    = {1'b0, upper - lower} + 17'd1;
  assign product = diff * levels;

  // quotient saturated at levels-1
  assign quot_sat_ref = DW'(levels - 1'b1);
  assign quot_level   = (div_rsp.quotient > quot_sat_ref) ? quot_sat_ref[7:0]
                                                          : div_rsp.quotient[7:0];

  // divider requests: bin count check from setup in bin width mode, level division from scale
  always_comb begin
    div_cmd.start    = 1'b0;
    div_cmd.dividend = '0;
    div_cmd.divisor  = '0;
    if (state == S_SETUP && cfg.method == mglq_pkg::MTH_BIN_WIDTH
        && err_s == mglq_pkg::ERR_NONE) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = {upper_s - lower_s, 8'd0};
      div_cmd.divisor  = cfg.bin_width_fx;
    end else if (state == S_SCALE) begin
      div_cmd.start = 1'b1;
      if (cfg.method == mglq_pkg::MTH_BIN_WIDTH) begin
        div_cmd.dividend = {diff, 8'd0};
        div_cmd.divisor  = cfg.bin_width_fx;
      end else begin
        div_cmd.dividend = product[DW-1:0];
        div_cmd.divisor  = DW'(span);
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && pixel.action == mglq_pkg::ACT_QUANTIZE) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (err_s != mglq_pkg::ERR_NONE) begin
          state_next = S_DONE;
        end else if (cfg.method == mglq_pkg::MTH_BIN_WIDTH) begin
          state_next = S_CHECK;
        end else if (cfg.method == mglq_pkg::MTH_PASS) begin
          state_next = S_DONE;
        end else if (in_mask && value > lower_s) begin
          state_next = S_SCALE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= DW'(levels)) begin
            state_next = S_DONE;
          end else if (in_mask && value > lower) begin
            state_next = S_SCALE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCALE: begin
        state_next = S_LEVEL_DIV;
      end
      S_LEVEL_DIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      value   <= pixel.pixel_value;
      in_mask <= item_inside;
    end
    if (state == S_SETUP) begin
      lower  <= lower_s;
      upper  <= upper_s;
      err    <= err_s;
      levels <= levels_s;
      if (err_s == mglq_pkg::ERR_NONE && cfg.method == mglq_pkg::MTH_PASS && in_mask) begin
        level <= pass_level;
      end else begin
        level <= '0;
      end
    end
    if (state == S_CHECK && div_rsp.done && div_rsp.quotient >= DW'(levels)) begin
      err <= mglq_pkg::ERR_TOO_MANY_BINS;
    end
    if (state == S_LEVEL_DIV && div_rsp.done) begin
      level <= quot_level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.level        <= level;
      result.error_code   <= err;
      result.lower_bound  <= lower;
      result.upper_bound  <= upper;
      result.inside_count <= stats.region_count;
    end
  end

  // an item with an error code never reports a nonzero level
  `MGLQ_ASSERT_ALWAYS(a_err_level_zero, (result_valid && result.error_code != mglq_pkg::ERR_NONE) |-> (result.level == '0), "level nonzero on error")
  // the divider is started only by the setup check or the scale step
  `MGLQ_ASSERT(a_div_start_src, div_cmd.start |-> (state == S_SETUP || state == S_SCALE), "divider started out of sequence")
  // a division finishes only while the sequencer waits for it
  `MGLQ_ASSERT(a_div_done_wait, div_rsp.done |-> (state == S_CHECK || state == S_LEVEL_DIV), "division finished unattended")
  // region statistics hold while an item is in work
  `MGLQ_ASSERT(a_stats_hold, (state != S_IDLE) |=> $stable(stats), "statistics changed while busy")

endmodule

`default_nettype wire
